// ===== hdl/qotmr_pkg.sv =====
// ----------------------------------------------------------------------------
// qotmr_pkg
// Shared types and constants of the quad one-shot timer with tick counter.
// ----------------------------------------------------------------------------
`default_nettype none

package qotmr_pkg;

    // counter geometry
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_CH      = 4;
    localparam int NUM_ONESHOT = 3;
    localparam logic [1:0] TICK_CH = 2'd3;

    // field widths
    localparam int ACTION_W = 3;
    localparam int CHANNEL_W = 2;
    localparam int VALUE_W  = 32;
    localparam int TPU_W    = 8;
    localparam int TPERIOD_W = 16;
    localparam int READ_W   = 32;
    localparam int PROD_W   = VALUE_W + TPU_W;
    localparam int RELOAD_PROD_W = TPERIOD_W + TPU_W;
    localparam int CFG_DATA_W = TPERIOD_W;

    // reset values
    localparam logic [63:0] PERIOD_SHORT = 64'd150000000;
    localparam logic [63:0] PERIOD_LONG  = 64'd300000000;
    localparam logic [TPU_W-1:0]     TPU_RESET     = 8'd150;
    localparam logic [TPERIOD_W-1:0] TPERIOD_RESET = 16'd1000;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_SET   = 3'd2,
        ACT_QUERY = 3'd3,
        ACT_STOP  = 3'd4
    } t_action;

    // configuration register indexes
    typedef enum logic {
        REG_TICKS_PER_US   = 1'b0,
        REG_TICK_PERIOD_US = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [CHANNEL_W-1:0] channel;
        logic [VALUE_W-1:0]   value_us;
    } t_in_item;

    typedef struct packed {
        logic [READ_W-1:0] read_value;
        logic [NUM_CH-1:0] expired_mask;
    } t_out_item;

    typedef struct packed {
        logic [TPU_W-1:0] ticks_per_us;
        t_count           reload;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hdl/qotmr_in_if.sv =====
// ----------------------------------------------------------------------------
// qotmr_in_if
// Valid/ready channel carrying one timer command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qotmr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [1:0]  channel;
    logic [31:0] value_us;

    modport source (output valid, output action, output channel, output value_us,
                    input ready);
    modport sink   (input valid, input action, input channel, input value_us,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/qotmr_out_if.sv =====
// ----------------------------------------------------------------------------
// qotmr_out_if
// Valid/ready channel carrying one timer result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qotmr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [3:0]  expired_mask;

    modport source (output valid, output read_value, output expired_mask, input ready);
    modport sink   (input valid, input read_value, input expired_mask, output ready);
endinterface

`default_nettype wire

// ===== hdl/qotmr_core.sv =====
// ----------------------------------------------------------------------------
// qotmr_core
// Timer state (counters, periods, run and done flags, tick total) and the
// next-state update for one registered command.
// ----------------------------------------------------------------------------
`default_nettype none

module qotmr_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire qotmr_pkg::t_in_item  i_item,
    input  wire qotmr_pkg::t_cfg      i_cfg,
    output qotmr_pkg::t_out_item      o_result
);

    qotmr_pkg::t_count r_count  [qotmr_pkg::NUM_CH];
    qotmr_pkg::t_count r_period [qotmr_pkg::NUM_CH];
    qotmr_pkg::t_count n_count  [qotmr_pkg::NUM_CH];
    qotmr_pkg::t_count n_period [qotmr_pkg::NUM_CH];
    logic [qotmr_pkg::NUM_CH-1:0]      r_running, n_running;
    logic [qotmr_pkg::NUM_ONESHOT-1:0] r_done, n_done;
    logic [qotmr_pkg::READ_W-1:0]      r_total, n_total;

    logic [qotmr_pkg::NUM_CH-1:0]  w_mask;
    logic [qotmr_pkg::READ_W-1:0]  w_read;
    logic [qotmr_pkg::PROD_W-1:0]  w_prod;
    qotmr_pkg::t_count             w_inc [qotmr_pkg::NUM_CH];

    // period requested by a set command
    assign w_prod = {{qotmr_pkg::TPU_W{1'b0}}, i_item.value_us}
                  * {{qotmr_pkg::VALUE_W{1'b0}}, i_cfg.ticks_per_us};

    // next state for the current command
    always_comb begin
        n_count   = r_count;
        n_period  = r_period;
        n_running = r_running;
        n_done    = r_done;
        n_total   = r_total;
        w_mask    = '0;
        w_read    = '0;
        for (int c = 0; c < qotmr_pkg::NUM_CH; c++) begin
            w_inc[c] = r_count[c] + qotmr_pkg::t_count'(1);
        end

        case (i_item.action)
            qotmr_pkg::ACT_TICK: begin
                for (int c = 0; c < qotmr_pkg::NUM_CH; c++) begin
                    if (r_running[c]) begin
                        if (w_inc[c] == r_period[c]) begin
                            w_mask[c]  = 1'b1;
                            n_count[c] = '0;
                            if (c == qotmr_pkg::NUM_CH - 1) begin
                                n_period[c] = i_cfg.reload;
                            end else begin
                                n_running[c] = 1'b0;
                            end
                        end else begin
                            n_count[c] = w_inc[c];
                        end
                    end
                end
                // sticky done for the one-shot channels, tick total for the periodic one
                n_done = r_done | w_mask[qotmr_pkg::NUM_ONESHOT-1:0];
                if (w_mask[qotmr_pkg::TICK_CH]) begin
                    n_total = r_total + qotmr_pkg::READ_W'(1);
                end
            end
            qotmr_pkg::ACT_START: begin
                n_running[i_item.channel] = 1'b1;
            end
            qotmr_pkg::ACT_SET: begin
                n_count[i_item.channel]   = '0;
                n_running[i_item.channel] = 1'b1;
                if (i_item.channel == qotmr_pkg::TICK_CH) begin
                    n_period[i_item.channel] = i_cfg.reload;
                end else begin
                    n_period[i_item.channel] = qotmr_pkg::t_count'(w_prod);
                    n_done[i_item.channel]   = 1'b0;
                end
            end
            qotmr_pkg::ACT_QUERY: begin
                if (i_item.channel == qotmr_pkg::TICK_CH) begin
                    w_read = r_total;
                end else begin
                    w_read = {{(qotmr_pkg::READ_W-1){1'b0}}, r_done[i_item.channel]};
                    n_done[i_item.channel] = 1'b0;
                end
            end
            qotmr_pkg::ACT_STOP: begin
                n_running[i_item.channel] = 1'b0;
                n_done = '0;
                if (i_item.channel == qotmr_pkg::TICK_CH) begin
                    n_total = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.read_value   = w_read;
    assign o_result.expired_mask = w_mask;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < qotmr_pkg::NUM_CH; c++) begin
                r_count[c] <= '0;
            end
            r_period[0] <= qotmr_pkg::t_count'(qotmr_pkg::PERIOD_SHORT);
            r_period[1] <= qotmr_pkg::t_count'(qotmr_pkg::PERIOD_LONG);
            r_period[2] <= qotmr_pkg::t_count'(qotmr_pkg::PERIOD_SHORT);
            r_period[3] <= qotmr_pkg::t_count'(qotmr_pkg::PERIOD_LONG);
            r_running <= '0;
            r_done    <= '0;
            r_total   <= '0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_period  <= n_period;
            r_running <= n_running;
            r_done    <= n_done;
            r_total   <= n_total;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/quad_oneshot_timer_with_tick_counter_top.sv =====
// Flow: a command transaction accepted into the input register is moved into the
// result register when that register is free or being drained.
// Throughput: one command per cycle while the output side keeps ready high.
// Reset: synchronous, active low; clears counters, flags and tick total, loads
// default periods and configuration, and empties both registers.
// ----------------------------------------------------------------------------
// quad_oneshot_timer_with_tick_counter_top
// Four up-counting timers: three one-shot channels and one periodic tick
// channel, driven by command transactions with a configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_oneshot_timer_with_tick_counter_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    qotmr_in_if.sink                              i_in,
    qotmr_out_if.source                           o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [qotmr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                               r_in_valid;
    qotmr_pkg::t_in_item                r_in;
    logic                               r_out_valid;
    qotmr_pkg::t_out_item               r_out;
    logic [qotmr_pkg::TPU_W-1:0]        r_tpu;
    logic [qotmr_pkg::TPERIOD_W-1:0]    r_tperiod;
    qotmr_pkg::t_count                  r_reload;
    logic [qotmr_pkg::RELOAD_PROD_W-1:0] w_reload_prod;
    qotmr_pkg::t_cfg                    w_cfg;
    qotmr_pkg::t_out_item               w_result;
    logic                               w_fire;
    logic                               w_in_ready;

    // handshake: process when the result register is free or being drained
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_fire;
    assign i_in.ready = w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_in.action   <= i_in.action;
            r_in.channel  <= i_in.channel;
            r_in.value_us <= i_in.value_us;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu     <= qotmr_pkg::TPU_RESET;
            r_tperiod <= qotmr_pkg::TPERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qotmr_pkg::REG_TICKS_PER_US:   r_tpu     <= i_cfg_data[qotmr_pkg::TPU_W-1:0];
                qotmr_pkg::REG_TICK_PERIOD_US: r_tperiod <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // periodic reload value, kept up to date from the configuration
    assign w_reload_prod = {{qotmr_pkg::TPU_W{1'b0}}, r_tperiod}
                         * {{qotmr_pkg::TPERIOD_W{1'b0}}, r_tpu};

    always_ff @(posedge i_clk) begin
        r_reload <= qotmr_pkg::t_count'(w_reload_prod);
    end

    assign w_cfg.ticks_per_us = r_tpu;
    assign w_cfg.reload       = r_reload;

    // timer state and update
    qotmr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_value   = r_out.read_value;
    assign o_out.expired_mask = r_out.expired_mask;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quad one-shot timer with tick counter. Timer
// commands are driven and results are taken over valid/ready links, with
// random gaps on both sides. A behavioral copy of the timers predicts every
// result, and each result is checked field by field. The run goes through
// several settings of the two configuration registers.
// ----------------------------------------------------------------------------

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 300;
    localparam int NUM_PHASES  = 5;
    localparam int SMALL_US_MAX = 16;
    // action codes the block must ignore
    localparam logic [qotmr_pkg::ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [qotmr_pkg::ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    // register settings per random phase, extremes included
    localparam logic [qotmr_pkg::TPU_W-1:0]     PHASE_TPU [NUM_PHASES] =
        '{8'd1, 8'd255, 8'd150, 8'd3, 8'd2};
    localparam logic [qotmr_pkg::TPERIOD_W-1:0] PHASE_TPER [NUM_PHASES] =
        '{16'd1, 16'd65535, 16'd1000, 16'd2, 16'd1};

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic                             i_cfg_idx;
    logic [qotmr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    qotmr_in_if  in_if ();
    qotmr_out_if out_if ();

    quad_oneshot_timer_with_tick_counter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // timer state as the block should hold it
    qotmr_pkg::t_count                count_st  [qotmr_pkg::NUM_CH];
    qotmr_pkg::t_count                period_st [qotmr_pkg::NUM_CH];
    logic                             run_st    [qotmr_pkg::NUM_CH];
    logic                             done_st   [qotmr_pkg::NUM_ONESHOT];
    logic [31:0]                      tick_total_st;
    logic [qotmr_pkg::TPU_W-1:0]      tpu_st;
    logic [qotmr_pkg::TPERIOD_W-1:0]  tper_st;

    qotmr_pkg::t_in_item  cmd_queue [$];
    qotmr_pkg::t_out_item due_results [$];
    qotmr_pkg::t_in_item  next_cmd;
    qotmr_pkg::t_in_item  seen_cmd;
    qotmr_pkg::t_out_item want;

    int  issued_cnt   = 0;
    int  accepted_cnt = 0;
    int  counted_cmds = 0;
    int  error_cnt    = 0;
    int  cycle_cnt    = 0;
    int  send_gap     = 0;
    int  recv_stall   = 0;
    int  recv_wait    = 0;
    bit  in_taken     = 1'b0;
    bit  out_taken    = 1'b0;
    bit  send_quiet   = 1'b0;
    bit  recv_quiet   = 1'b0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void reset_timers();
        for (int c = 0; c < qotmr_pkg::NUM_CH; c++) begin
            count_st[c] = '0;
            run_st[c]   = 1'b0;
        end
        period_st[0] = qotmr_pkg::t_count'(qotmr_pkg::PERIOD_SHORT);
        period_st[1] = qotmr_pkg::t_count'(qotmr_pkg::PERIOD_LONG);
        period_st[2] = qotmr_pkg::t_count'(qotmr_pkg::PERIOD_SHORT);
        period_st[3] = qotmr_pkg::t_count'(qotmr_pkg::PERIOD_LONG);
        for (int c = 0; c < qotmr_pkg::NUM_ONESHOT; c++) done_st[c] = 1'b0;
        tick_total_st = '0;
        tpu_st  = qotmr_pkg::TPU_RESET;
        tper_st = qotmr_pkg::TPERIOD_RESET;
    endfunction

    function automatic qotmr_pkg::t_count tick_reload();
        return qotmr_pkg::t_count'(32'(tper_st) * 32'(tpu_st));
    endfunction

    // advance the timers by one command and return its result
    function automatic qotmr_pkg::t_out_item apply_command(qotmr_pkg::t_in_item cmd);
        qotmr_pkg::t_out_item res;
        qotmr_pkg::t_count    nxt;
        int                   c;
        res = '0;
        case (cmd.action)
            qotmr_pkg::ACT_TICK: begin
                for (c = 0; c < qotmr_pkg::NUM_CH; c++) begin
                    if (run_st[c]) begin
                        nxt = count_st[c] + 1'b1;
                        if (nxt == period_st[c]) begin
                            res.expired_mask[c] = 1'b1;
                            count_st[c] = '0;
                            if (c == qotmr_pkg::TICK_CH) begin
                                period_st[c]  = tick_reload();
                                tick_total_st = tick_total_st + 1'b1;
                            end else begin
                                run_st[c]  = 1'b0;
                                done_st[c] = 1'b1;
                            end
                        end else begin
                            count_st[c] = nxt;
                        end
                    end
                end
            end
            qotmr_pkg::ACT_START: begin
                run_st[cmd.channel] = 1'b1;
            end
            qotmr_pkg::ACT_SET: begin
                count_st[cmd.channel] = '0;
                if (cmd.channel == qotmr_pkg::TICK_CH) begin
                    period_st[cmd.channel] = tick_reload();
                end else begin
                    period_st[cmd.channel] =
                        qotmr_pkg::t_count'(64'(cmd.value_us) * 64'(tpu_st));
                    done_st[cmd.channel]   = 1'b0;
                end
                run_st[cmd.channel] = 1'b1;
            end
            qotmr_pkg::ACT_QUERY: begin
                if (cmd.channel == qotmr_pkg::TICK_CH) begin
                    res.read_value = tick_total_st;
                end else begin
                    res.read_value = {31'b0, done_st[cmd.channel]};
                    done_st[cmd.channel] = 1'b0;
                end
            end
            qotmr_pkg::ACT_STOP: begin
                run_st[cmd.channel] = 1'b0;
                for (c = 0; c < qotmr_pkg::NUM_ONESHOT; c++) done_st[c] = 1'b0;
                if (cmd.channel == qotmr_pkg::TICK_CH) tick_total_st = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // per-transaction wait, with quiet stretches of back-to-back traffic
    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 47) == 0) quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        error_cnt++;
        $display("mismatch on %s: expected %0h, got %0h at %0t",
                 what, exp_val, got_val, $realtime);
    endtask

    task automatic queue_cmd(input logic [qotmr_pkg::ACTION_W-1:0] act,
                             input logic [1:0] chan, input logic [31:0] val);
        qotmr_pkg::t_in_item cmd;
        cmd.action   = act;
        cmd.channel  = chan;
        cmd.value_us = val;
        cmd_queue.push_back(cmd);
        issued_cnt++;
        if (act <= qotmr_pkg::ACT_STOP) counted_cmds++;
    endtask

    task automatic configure(input logic [qotmr_pkg::TPU_W-1:0] tpu,
                             input logic [qotmr_pkg::TPERIOD_W-1:0] tper);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= qotmr_pkg::REG_TICKS_PER_US;
        i_cfg_data <= qotmr_pkg::CFG_DATA_W'(tpu);
        @(negedge i_clk);
        i_cfg_idx  <= qotmr_pkg::REG_TICK_PERIOD_US;
        i_cfg_data <= tper;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tpu_st  = tpu;
        tper_st = tper;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (accepted_cnt != issued_cnt || due_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // random commands, largely set / run / query sequences on one channel
    task automatic fill_random_phase(input int n);
        logic [1:0]  chan;
        logic [31:0] val;
        int          pick;
        counted_cmds = 0;
        while (counted_cmds < n) begin
            chan = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 3) begin
                val = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, SMALL_US_MAX);
                queue_cmd(qotmr_pkg::ACT_SET, chan, val);
                repeat ($urandom_range(1, 24))
                    queue_cmd(qotmr_pkg::ACT_TICK, 2'($urandom), $urandom);
                queue_cmd(qotmr_pkg::ACT_QUERY, chan, $urandom);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    queue_cmd(qotmr_pkg::ACT_TICK, chan, $urandom);
                else if (pick < 55)
                    queue_cmd(qotmr_pkg::ACT_START, chan, $urandom);
                else if (pick < 68)
                    queue_cmd(qotmr_pkg::ACT_SET, chan, ($urandom_range(0, 3) == 0) ?
                              $urandom : $urandom_range(0, SMALL_US_MAX));
                else if (pick < 82)
                    queue_cmd(qotmr_pkg::ACT_QUERY, chan, $urandom);
                else if (pick < 96)
                    queue_cmd(qotmr_pkg::ACT_STOP, chan, $urandom);
                else
                    queue_cmd(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), chan, $urandom);
            end
        end
    endtask

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (in_if.valid && !in_taken) begin
            // hold the transaction until it is taken
        end else if (send_gap != 0) begin
            in_if.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end else if (cmd_queue.size() != 0) begin
            next_cmd = cmd_queue.pop_front();
            in_if.action   <= next_cmd.action;
            in_if.channel  <= next_cmd.channel;
            in_if.value_us <= next_cmd.value_us;
            in_if.valid    <= 1'b1;
            send_gap       <= draw_wait(send_quiet);
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // result backpressure, a drawn wait of zero keeps ready high
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall   <= 0;
        end else if (out_taken) begin
            recv_wait = draw_wait(recv_quiet);
            out_if.ready <= (recv_wait == 0);
            recv_stall   <= (recv_wait == 0) ? 0 : recv_wait - 1;
        end else if (recv_stall != 0) begin
            out_if.ready <= 1'b0;
            recv_stall   <= recv_stall - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge i_clk) begin
        in_taken  <= in_if.valid && in_if.ready;
        out_taken <= out_if.valid && out_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            seen_cmd.action   = in_if.action;
            seen_cmd.channel  = in_if.channel;
            seen_cmd.value_us = in_if.value_us;
            due_results.push_back(apply_command(seen_cmd));
            accepted_cnt++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_results.size() == 0) begin
                flag_mismatch("unexpected result", '0, out_if.read_value);
            end else begin
                want = due_results.pop_front();
                if (out_if.read_value !== want.read_value)
                    flag_mismatch("read_value", want.read_value, out_if.read_value);
                if (out_if.expired_mask !== want.expired_mask)
                    flag_mismatch("expired_mask", 32'(want.expired_mask),
                                  32'(out_if.expired_mask));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = qotmr_pkg::REG_TICKS_PER_US;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.action   = qotmr_pkg::ACT_TICK;
        in_if.channel  = '0;
        in_if.value_us = '0;
        out_if.ready   = 1'b0;
        reset_timers();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small periods so channels 0, 1 and the tick channel expire quickly
        configure(8'd2, 16'd3);
        queue_cmd(qotmr_pkg::ACT_QUERY, 2'd0, 32'h0);
        queue_cmd(qotmr_pkg::ACT_QUERY, qotmr_pkg::TICK_CH, 32'h0);
        queue_cmd(qotmr_pkg::ACT_SET, 2'd0, 32'd2);
        // product wraps to a period of two
        queue_cmd(qotmr_pkg::ACT_SET, 2'd1, 32'h8000_0001);
        // zero period only expires on counter wrap
        queue_cmd(qotmr_pkg::ACT_SET, 2'd2, 32'h0);
        // tick channel ignores the requested value
        queue_cmd(qotmr_pkg::ACT_SET, qotmr_pkg::TICK_CH, 32'hFFFF_FFFF);
        repeat (6) queue_cmd(qotmr_pkg::ACT_TICK, 2'd0, 32'h0);
        queue_cmd(qotmr_pkg::ACT_QUERY, 2'd1, 32'h0);
        queue_cmd(qotmr_pkg::ACT_QUERY, 2'd1, 32'h0);
        queue_cmd(qotmr_pkg::ACT_QUERY, qotmr_pkg::TICK_CH, 32'h0);
        // start keeps the old period and count
        queue_cmd(qotmr_pkg::ACT_START, 2'd1, 32'hFFFF_FFFF);
        queue_cmd(qotmr_pkg::ACT_TICK, 2'd3, 32'hFFFF_FFFF);
        queue_cmd(qotmr_pkg::ACT_TICK, 2'd2, 32'h5555_AAAA);
        // stop on any channel clears every done flag
        queue_cmd(qotmr_pkg::ACT_STOP, 2'd2, 32'h0);
        queue_cmd(qotmr_pkg::ACT_QUERY, 2'd0, 32'h0);
        queue_cmd(qotmr_pkg::ACT_STOP, qotmr_pkg::TICK_CH, 32'h0);
        queue_cmd(qotmr_pkg::ACT_QUERY, qotmr_pkg::TICK_CH, 32'h0);
        queue_cmd(ACT_SPARE_HI, qotmr_pkg::TICK_CH, 32'hFFFF_FFFF);
        queue_cmd(qotmr_pkg::ACT_SET, 2'd0, 32'hFFFF_FFFF);
        queue_cmd(qotmr_pkg::ACT_START, qotmr_pkg::TICK_CH, 32'h0);
        queue_cmd(qotmr_pkg::ACT_TICK, 2'd0, 32'h0);
        wait_drained();

        // random phases over several register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(PHASE_TPU[p], PHASE_TPER[p]);
            fill_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
